// ===== rtl/rldf_pkg.sv =====
`timescale 1ns / 1ps

package rldf_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam int CLUE_MAX_DEF = 16;

    localparam int CLUE_W      = 6;
    localparam int DOM_W       = 2;
    localparam int STAT_W      = 2;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    localparam logic [DOM_W-1:0] DOM_EMPTY  = 2'b01;
    localparam logic [DOM_W-1:0] DOM_FILLED = 2'b10;

    localparam logic ACT_CLUE = 1'b0;
    localparam logic ACT_CELL = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_CONTRA   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

    typedef struct packed {
        logic             clear;
        logic             shift;
        logic             f_init;
        logic             f_step;
        logic             b_init;
        logic             b_step;
        logic [DOM_W-1:0] dom;
    } rldf_cmd_t;

    typedef struct packed {
        logic adv;
        logic fill;
        logic loop;
        logic f;
    } rldf_link_t;

    typedef struct packed {
        logic acc;
        logic ce;
        logic cf;
    } rldf_flag_t;

endpackage

// ===== rtl/rldf_cell.sv =====
`timescale 1ns / 1ps

module rldf_cell #(
    parameter int LINE_MAX = rldf_pkg::LINE_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rldf_pkg::rldf_cmd_t  cmd,
    input  rldf_pkg::rldf_link_t lo_in,
    input  logic                 hi_b,
    output rldf_pkg::rldf_link_t up_out,
    output logic                 b_out,
    output rldf_pkg::rldf_flag_t flag_out
);

    logic adv_reg, adv_next;
    logic fill_reg, fill_next;
    logic loop_reg, loop_next;
    logic f_reg, f_next;
    logic b_reg, b_next;
    logic [LINE_MAX:0] stack_reg, stack_next;

    logic de, df, last, go_e, go_f, fwd, bwd;

    always_comb begin
        de   = |(cmd.dom & rldf_pkg::DOM_EMPTY);
        df   = |(cmd.dom & rldf_pkg::DOM_FILLED);
        last = !adv_reg && lo_in.adv;
        go_e = (loop_reg && b_reg) || (adv_reg && !fill_reg && hi_b);
        go_f = adv_reg && fill_reg && hi_b;
        fwd  = (f_reg && de && loop_reg) ||
               (lo_in.f && lo_in.adv && ((de && !lo_in.fill) || (df && lo_in.fill)));
        bwd  = (de && go_e) || (df && go_f);
    end

    always_comb begin
        adv_next   = adv_reg;
        fill_next  = fill_reg;
        loop_next  = loop_reg;
        f_next     = f_reg;
        b_next     = b_reg;
        stack_next = stack_reg;
        priority if (cmd.clear) begin
            adv_next  = 1'b0;
            fill_next = 1'b0;
            loop_next = 1'b1;
            f_next    = 1'b0;
            b_next    = 1'b0;
        end else if (cmd.shift) begin
            adv_next  = lo_in.adv;
            fill_next = lo_in.fill;
            loop_next = lo_in.loop;
        end else if (cmd.f_init) begin
            f_next = lo_in.f;
        end else if (cmd.f_step) begin
            f_next     = fwd;
            stack_next = {stack_reg[LINE_MAX-1:0], f_reg};
        end else if (cmd.b_init) begin
            b_next = last;
        end else if (cmd.b_step) begin
            b_next     = bwd;
            stack_next = {1'b0, stack_reg[LINE_MAX:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adv_reg  <= 1'b0;
            fill_reg <= 1'b0;
            loop_reg <= 1'b1;
            f_reg    <= 1'b0;
            b_reg    <= 1'b0;
        end else begin
            adv_reg  <= adv_next;
            fill_reg <= fill_next;
            loop_reg <= loop_next;
            f_reg    <= f_next;
            b_reg    <= b_next;
        end
        stack_reg <= stack_next;
    end

    assign up_out.adv   = adv_reg;
    assign up_out.fill  = fill_reg;
    assign up_out.loop  = loop_reg;
    assign up_out.f     = f_reg;
    assign b_out        = b_reg;
    assign flag_out.acc = f_reg && last;
    assign flag_out.ce  = de && go_e && stack_reg[0];
    assign flag_out.cf  = df && go_f && stack_reg[0];

endmodule

// ===== rtl/rldf_ctrl.sv =====
`timescale 1ns / 1ps

module rldf_ctrl #(
    parameter int LINE_MAX = rldf_pkg::LINE_MAX_DEF,
    parameter int CLUE_MAX = rldf_pkg::CLUE_MAX_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rldf_pkg::TDATA_IN_W-1:0]      s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rldf_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic [rldf_pkg::STAT_W-1:0]          m_tuser,
    output logic                                 m_tlast,
    output rldf_pkg::rldf_cmd_t                  cmd,
    output rldf_pkg::rldf_link_t                 sym,
    input  rldf_pkg::rldf_flag_t                 flags
);

    localparam int CW    = $clog2(LINE_MAX + 1);
    localparam int IW    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CCW   = $clog2(CLUE_MAX + 1);
    localparam int JW    = (CLUE_MAX > 1) ? $clog2(CLUE_MAX) : 1;
    localparam int LW    = $clog2(LINE_MAX + 2);
    localparam int CMP_W = (CW > rldf_pkg::CLUE_W) ? CW : rldf_pkg::CLUE_W;
    localparam int DW    = rldf_pkg::DOM_W;
    localparam int KW    = rldf_pkg::CLUE_W;

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_CL_RD   = 4'd2;
    localparam logic [3:0] S_CL_CHK  = 4'd3;
    localparam logic [3:0] S_SH_FILL = 4'd4;
    localparam logic [3:0] S_SH_SEP  = 4'd5;
    localparam logic [3:0] S_LEN_CHK = 4'd6;
    localparam logic [3:0] S_F_INIT  = 4'd7;
    localparam logic [3:0] S_F_RD    = 4'd8;
    localparam logic [3:0] S_F_STEP  = 4'd9;
    localparam logic [3:0] S_F_CHK   = 4'd10;
    localparam logic [3:0] S_B_RD    = 4'd11;
    localparam logic [3:0] S_B_STEP  = 4'd12;
    localparam logic [3:0] S_E_RD    = 4'd13;
    localparam logic [3:0] S_E_OUT   = 4'd14;
    localparam logic [3:0] S_FAIL    = 4'd15;

    logic [3:0]                  state_reg, state_next;
    logic [CCW-1:0]              clue_cnt_reg, clue_cnt_next;
    logic [CW-1:0]               cell_cnt_reg, cell_cnt_next;
    logic [1:0]                  err_reg, err_next;
    logic [JW-1:0]               j_reg, j_next;
    logic [KW-1:0]               t_reg, t_next;
    logic [LW-1:0]               len_reg, len_next;
    logic [IW-1:0]               i_reg, i_next;
    logic [rldf_pkg::STAT_W-1:0] fail_reg, fail_next;
    logic                        m_valid_reg;
    logic [DW-1:0]               m_dom_reg;
    logic [rldf_pkg::STAT_W-1:0] m_stat_reg;
    logic                        m_last_reg;

    logic [KW-1:0] clue_mem [CLUE_MAX];
    logic [DW-1:0] dom_mem  [LINE_MAX];
    logic [KW-1:0] clue_rd_reg;
    logic [DW-1:0] dom_rd_reg;

    logic                        clue_we, dom_we, load_out, out_free;
    logic [IW-1:0]               dom_wa;
    logic [DW-1:0]               dom_wd, nd, out_dom;
    logic [rldf_pkg::STAT_W-1:0] out_stat;
    logic                        out_last;
    logic [CW-1:0]               n_m1;
    logic [LW-1:0]               len_inc;

    assign out_free = !m_valid_reg || m_tready;
    assign n_m1     = cell_cnt_reg - 1'b1;
    assign len_inc  = (len_reg == LW'(LINE_MAX + 1)) ? len_reg : len_reg + 1'b1;
    assign nd       = {flags.cf, flags.ce};

    always_comb begin
        state_next    = state_reg;
        clue_cnt_next = clue_cnt_reg;
        cell_cnt_next = cell_cnt_reg;
        err_next      = err_reg;
        j_next        = j_reg;
        t_next        = t_reg;
        len_next      = len_reg;
        i_next        = i_reg;
        fail_next     = fail_reg;
        cmd           = '0;
        sym           = '0;
        sym.adv       = 1'b1;
        s_tready      = 1'b0;
        clue_we       = 1'b0;
        dom_we        = 1'b0;
        dom_wa        = cell_cnt_reg[IW-1:0];
        dom_wd        = s_tdata[KW+DW-1:KW];
        load_out      = 1'b0;
        out_dom       = '0;
        out_stat      = rldf_pkg::STAT_OK;
        out_last      = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == rldf_pkg::ACT_CLUE) begin
                        if (clue_cnt_reg < CCW'(CLUE_MAX)) begin
                            clue_we       = 1'b1;
                            clue_cnt_next = clue_cnt_reg + 1'b1;
                        end else begin
                            err_next[0] = 1'b1;
                        end
                    end else begin
                        if (cell_cnt_reg < CW'(LINE_MAX)) begin
                            dom_we        = 1'b1;
                            cell_cnt_next = cell_cnt_reg + 1'b1;
                        end else begin
                            err_next[1] = 1'b1;
                        end
                        if (s_tlast) begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                cmd.clear = 1'b1;
                len_next  = '0;
                if (err_reg != 2'b00) begin
                    fail_next  = rldf_pkg::STAT_OVERFLOW;
                    state_next = S_FAIL;
                end else if (clue_cnt_reg == '0) begin
                    state_next = S_F_INIT;
                end else begin
                    j_next     = JW'(clue_cnt_reg - 1'b1);
                    state_next = S_CL_RD;
                end
            end
            S_CL_RD: begin
                state_next = S_CL_CHK;
            end
            S_CL_CHK: begin
                if (clue_rd_reg == '0 || CMP_W'(clue_rd_reg) > CMP_W'(cell_cnt_reg)) begin
                    fail_next  = rldf_pkg::STAT_INVALID;
                    state_next = S_FAIL;
                end else begin
                    t_next     = clue_rd_reg - 1'b1;
                    state_next = S_SH_FILL;
                end
            end
            S_SH_FILL: begin
                cmd.shift = 1'b1;
                sym.fill  = 1'b1;
                sym.loop  = (t_reg == '0);
                len_next  = len_inc;
                if (t_reg == '0) begin
                    state_next = (j_reg == '0) ? S_LEN_CHK : S_SH_SEP;
                end else begin
                    t_next = t_reg - 1'b1;
                end
            end
            S_SH_SEP: begin
                cmd.shift  = 1'b1;
                len_next   = len_inc;
                j_next     = j_reg - 1'b1;
                state_next = S_CL_RD;
            end
            S_LEN_CHK: begin
                if (len_reg > LW'(cell_cnt_reg)) begin
                    fail_next  = rldf_pkg::STAT_CONTRA;
                    state_next = S_FAIL;
                end else begin
                    state_next = S_F_INIT;
                end
            end
            S_F_INIT: begin
                cmd.f_init = 1'b1;
                sym.f      = 1'b1;
                i_next     = '0;
                state_next = S_F_RD;
            end
            S_F_RD: begin
                state_next = S_F_STEP;
            end
            S_F_STEP: begin
                cmd.f_step = 1'b1;
                cmd.dom    = dom_rd_reg;
                if (CW'(i_reg) == n_m1) begin
                    state_next = S_F_CHK;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_F_CHK: begin
                if (!flags.acc) begin
                    fail_next  = rldf_pkg::STAT_CONTRA;
                    state_next = S_FAIL;
                end else begin
                    cmd.b_init = 1'b1;
                    i_next     = IW'(n_m1);
                    state_next = S_B_RD;
                end
            end
            S_B_RD: begin
                state_next = S_B_STEP;
            end
            S_B_STEP: begin
                cmd.b_step = 1'b1;
                cmd.dom    = dom_rd_reg;
                if (nd == '0) begin
                    fail_next  = rldf_pkg::STAT_CONTRA;
                    state_next = S_FAIL;
                end else begin
                    dom_we = 1'b1;
                    dom_wa = i_reg;
                    dom_wd = nd;
                    if (i_reg == '0) begin
                        state_next = S_E_RD;
                    end else begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_B_RD;
                    end
                end
            end
            S_E_RD: begin
                state_next = S_E_OUT;
            end
            S_E_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_dom  = dom_rd_reg;
                    out_last = (CW'(i_reg) == n_m1);
                    if (out_last) begin
                        clue_cnt_next = '0;
                        cell_cnt_next = '0;
                        err_next      = '0;
                        state_next    = S_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_E_RD;
                    end
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_stat      = fail_reg;
                    out_last      = 1'b1;
                    clue_cnt_next = '0;
                    cell_cnt_next = '0;
                    err_next      = '0;
                    state_next    = S_LOAD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            clue_cnt_reg <= '0;
            cell_cnt_reg <= '0;
            err_reg      <= '0;
            j_reg        <= '0;
            t_reg        <= '0;
            len_reg      <= '0;
            i_reg        <= '0;
            fail_reg     <= rldf_pkg::STAT_OK;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clue_cnt_reg <= clue_cnt_next;
            cell_cnt_reg <= cell_cnt_next;
            err_reg      <= err_next;
            j_reg        <= j_next;
            t_reg        <= t_next;
            len_reg      <= len_next;
            i_reg        <= i_next;
            fail_reg     <= fail_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load_out) begin
            m_dom_reg  <= out_dom;
            m_stat_reg <= out_stat;
            m_last_reg <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (clue_we) begin
            clue_mem[clue_cnt_reg[JW-1:0]] <= s_tdata[KW-1:0];
        end
        clue_rd_reg <= clue_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (dom_we) begin
            dom_mem[dom_wa] <= dom_wd;
        end
        dom_rd_reg <= dom_mem[i_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rldf_pkg::TDATA_OUT_W - DW){1'b0}}, m_dom_reg};
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/runlength_line_domain_filter_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  tdata                              tuser                 tlast
// s_       in         [5:0] clue_length, [7:6] cell_dom  [0] action            last_cell
// m_       out        [1:0] new_domain, [7:2] zero       [1:0] status          last_result
//
// Clue and cell items are taken while s_tready is high; a cell item marked tlast
// starts the solve, which reads each clue and shifts its pattern symbols into the cell row,
// then runs a forward pass and a backward pass over the cells through the registered read
// of the domain memory, then sends the result items, which the output may stall, with
// checks between the passes.
// Reset is synchronous and active low; the cell stores need no clearing.
// s_tready stays low from the line's last item until its final result is registered.

module runlength_line_domain_filter_top #(
    parameter int LINE_MAX = rldf_pkg::LINE_MAX_DEF,
    parameter int CLUE_MAX = rldf_pkg::CLUE_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rldf_pkg::TDATA_IN_W-1:0]  s_tdata,  // clue_length, cell_domain
    input  logic                             s_tuser,  // action
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rldf_pkg::TDATA_OUT_W-1:0] m_tdata,  // new_domain
    output logic [rldf_pkg::STAT_W-1:0]      m_tuser,  // status
    output logic                             m_tlast
);

    rldf_pkg::rldf_cmd_t  cmd;
    rldf_pkg::rldf_link_t link [LINE_MAX+1];
    rldf_pkg::rldf_flag_t flag [LINE_MAX+1];
    rldf_pkg::rldf_flag_t flags;
    logic [LINE_MAX+1:0]  bvec;
    logic [LINE_MAX:0]    acc_vec, ce_vec, cf_vec;

    assign bvec[LINE_MAX+1] = 1'b0;

    genvar k;
    generate
        for (k = 0; k <= LINE_MAX; k++) begin : g_cell
            if (k == LINE_MAX) begin : g_top
                rldf_cell #(.LINE_MAX(LINE_MAX)) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .cmd      (cmd),
                    .lo_in    (link[k]),
                    .hi_b     (bvec[k+1]),
                    .up_out   (),
                    .b_out    (bvec[k]),
                    .flag_out (flag[k])
                );
            end else begin : g_mid
                rldf_cell #(.LINE_MAX(LINE_MAX)) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .cmd      (cmd),
                    .lo_in    (link[k]),
                    .hi_b     (bvec[k+1]),
                    .up_out   (link[k+1]),
                    .b_out    (bvec[k]),
                    .flag_out (flag[k])
                );
            end
            assign acc_vec[k] = flag[k].acc;
            assign ce_vec[k]  = flag[k].ce;
            assign cf_vec[k]  = flag[k].cf;
        end
    endgenerate

    assign flags.acc = |acc_vec;
    assign flags.ce  = |ce_vec;
    assign flags.cf  = |cf_vec;

    rldf_ctrl #(
        .LINE_MAX (LINE_MAX),
        .CLUE_MAX (CLUE_MAX)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sym      (link[0]),
        .flags    (flags)
    );

    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != rldf_pkg::STAT_OK) |-> m_tlast)
        else $error("failure item not marked last");

    a_fail_no_domain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != rldf_pkg::STAT_OK) |-> (m_tdata == '0))
        else $error("failure item carries a domain");

    a_busy_after_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == rldf_pkg::ACT_CELL && s_tlast) |=> !s_tready)
        else $error("input taken while a line is being solved");

    a_cells_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.f_step || cmd.b_step || cmd.shift))
        else $error("cell row active while loading");

endmodule

// ===== tb/runlength_line_domain_filter_top_tb.sv =====
`timescale 1ns / 1ps

module runlength_line_domain_filter_top_tb;

    localparam int LINES = 32;
    localparam int CLUES = 16;

    typedef struct {
        logic [rldf_pkg::DOM_W-1:0]  dom;
        logic [rldf_pkg::STAT_W-1:0] stat;
        logic                        last;
    } domain_result_t;

    typedef struct {
        logic                        act;
        logic [5:0]                  clen;
        logic [rldf_pkg::DOM_W-1:0]  dom;
        logic                        last;
        bit                          typed;
        logic [rldf_pkg::DOM_W-1:0]  tdom;
        logic [rldf_pkg::STAT_W-1:0] tstat;
    } stim_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rldf_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rldf_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic [rldf_pkg::STAT_W-1:0]      m_tuser;
    logic                             m_tlast;

    domain_result_t             narrowed_q[$];
    logic [5:0]                 clue_mem[CLUES];
    logic [rldf_pkg::DOM_W-1:0] cell_mem[LINES];
    int                         n_clues = 0;
    int                         n_cells = 0;
    logic [1:0]                 ovf_flags = '0;
    int                         mismatches = 0;
    int                         lines_done = 0;
    int                         results_seen = 0;
    int                         items_sent = 0;
    bit                         no_gaps = 1'b0;
    int                         stall_left = 0;

    runlength_line_domain_filter_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void add_expected(domain_result_t r);
        narrowed_q.insert(narrowed_q.size(), r);
    endfunction

    function automatic void push_fail(logic [rldf_pkg::STAT_W-1:0] code);
        add_expected('{dom: '0, stat: code, last: 1'b1});
    endfunction

    // Forward and backward reachability through the run-length pattern automaton.
    function automatic void narrow_line();
        int                         len;
        int                         sum;
        int                         k;
        logic [32:0]                is_fill;
        logic [32:0]                may_loop;
        logic [32:0]                fwd[0:LINES];
        logic [32:0]                bwd;
        logic [32:0]                nxt;
        logic [rldf_pkg::DOM_W-1:0] d;
        logic [rldf_pkg::DOM_W-1:0] res[LINES];
        bit                         e;
        bit                         f;
        bit                         can_e;
        bit                         can_f;
        sum = 0;
        if (ovf_flags != 0) begin
            push_fail(rldf_pkg::STAT_OVERFLOW);
            return;
        end
        for (int j = 0; j < n_clues; j++) begin
            if (clue_mem[j] == 0 || clue_mem[j] > n_cells) begin
                push_fail(rldf_pkg::STAT_INVALID);
                return;
            end
            sum += clue_mem[j];
        end
        len = (n_clues == 0) ? 0 : sum + n_clues - 1;
        if (len > n_cells) begin
            push_fail(rldf_pkg::STAT_CONTRA);
            return;
        end
        is_fill = '0;
        may_loop = '0;
        may_loop[0] = 1'b1;
        k = 0;
        for (int j = 0; j < n_clues; j++) begin
            if (j > 0) begin
                k++;
                may_loop[k] = 1'b1;
            end
            for (int t = 0; t < clue_mem[j]; t++) begin
                is_fill[k] = 1'b1;
                k++;
            end
        end
        may_loop[len] = 1'b1;
        fwd[0] = '0;
        fwd[0][0] = 1'b1;
        for (int i = 0; i < n_cells; i++) begin
            d = cell_mem[i];
            fwd[i+1] = '0;
            for (int s = 0; s <= len; s++) begin
                if (fwd[i][s]) begin
                    if (d & rldf_pkg::DOM_EMPTY) begin
                        if (may_loop[s]) fwd[i+1][s] = 1'b1;
                        if (s < len && !is_fill[s]) fwd[i+1][s+1] = 1'b1;
                    end
                    if ((d & rldf_pkg::DOM_FILLED) && s < len && is_fill[s])
                        fwd[i+1][s+1] = 1'b1;
                end
            end
        end
        if (!fwd[n_cells][len]) begin
            push_fail(rldf_pkg::STAT_CONTRA);
            return;
        end
        bwd = '0;
        bwd[len] = 1'b1;
        for (int i = n_cells - 1; i >= 0; i--) begin
            d = cell_mem[i];
            can_e = 0;
            can_f = 0;
            nxt = '0;
            for (int s = 0; s <= len; s++) begin
                e = (may_loop[s] && bwd[s]) || (s < len && !is_fill[s] && bwd[s+1]);
                f = s < len && is_fill[s] && bwd[s+1];
                if ((d & rldf_pkg::DOM_EMPTY) && e) begin
                    nxt[s] = 1'b1;
                    if (fwd[i][s]) can_e = 1;
                end
                if ((d & rldf_pkg::DOM_FILLED) && f) begin
                    nxt[s] = 1'b1;
                    if (fwd[i][s]) can_f = 1;
                end
            end
            res[i] = (can_e ? rldf_pkg::DOM_EMPTY : 2'b00) |
                     (can_f ? rldf_pkg::DOM_FILLED : 2'b00);
            if (res[i] == 0) begin
                push_fail(rldf_pkg::STAT_CONTRA);
                return;
            end
            bwd = nxt;
        end
        for (int i = 0; i < n_cells; i++)
            add_expected('{dom: res[i], stat: rldf_pkg::STAT_OK, last: i == n_cells - 1});
    endfunction

    function automatic void take_item(stim_row_t r);
        if (r.act == rldf_pkg::ACT_CLUE) begin
            if (n_clues < CLUES) begin
                clue_mem[n_clues] = r.clen;
                n_clues++;
            end else begin
                ovf_flags[0] = 1'b1;
            end
            return;
        end
        if (n_cells < LINES) begin
            cell_mem[n_cells] = r.dom;
            n_cells++;
        end else begin
            ovf_flags[1] = 1'b1;
        end
        if (!r.last)
            return;
        if (r.typed)
            add_expected('{dom: r.tdom, stat: r.tstat, last: 1'b1});
        else
            narrow_line();
        lines_done++;
        n_clues = 0;
        n_cells = 0;
        ovf_flags = '0;
    endfunction

    task automatic send_item(stim_row_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {r.dom, r.clen};
        s_tuser <= r.act;
        s_tlast <= r.last;
        do @(posedge aclk); while (!s_tready);
        take_item(r);
        items_sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic stim_row_t clue_row(logic [5:0] c, logic lst = 1'b0);
        return '{act: rldf_pkg::ACT_CLUE, clen: c, dom: 2'($urandom), last: lst,
                 typed: 0, tdom: '0, tstat: rldf_pkg::STAT_OK};
    endfunction

    function automatic stim_row_t cell_row(logic [1:0] d, logic lst);
        return '{act: rldf_pkg::ACT_CELL, clen: 6'($urandom), dom: d, last: lst,
                 typed: 0, tdom: '0, tstat: rldf_pkg::STAT_OK};
    endfunction

    function automatic stim_row_t typed_row(logic [1:0] d, logic [1:0] td,
                                            logic [rldf_pkg::STAT_W-1:0] ts);
        stim_row_t r;
        r = cell_row(d, 1'b1);
        r.typed = 1;
        r.tdom = td;
        r.tstat = ts;
        return r;
    endfunction

    // A random line: clues come from a hidden solution unless randomized, domains are hints of it or random.
    task automatic send_random_line();
        int          n;
        int          run;
        int          mode;
        logic [31:0] sol;
        logic [5:0]  runs[$];
        logic [1:0]  d;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 10);
        mode = $urandom_range(0, 9);
        sol = $urandom;
        run = 0;
        for (int i = 0; i < n; i++) begin
            if (sol[i]) run++;
            if ((!sol[i] || i == n - 1) && run > 0) begin
                runs.insert(runs.size(), 6'(run));
                run = 0;
            end
        end
        if (mode == 0)
            foreach (runs[j]) runs[j] = 6'($urandom);
        foreach (runs[j]) send_item(clue_row(runs[j], 1'($urandom_range(0, 7) == 0)));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0, 1: d = 2'b11;
                2:    d = 2'($urandom);
                default: d = sol[i] ? rldf_pkg::DOM_FILLED : rldf_pkg::DOM_EMPTY;
            endcase
            send_item(cell_row(d, i == n - 1));
        end
    endtask

    always @(posedge aclk) begin
        domain_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (narrowed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: dom %0d status %0d last %0d",
                             m_tdata[1:0], m_tuser, m_tlast);
            end else begin
                want = narrowed_q[0];
                narrowed_q.delete(0);
                if (m_tdata !== {6'b0, want.dom} || m_tuser !== want.stat
                        || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected dom %0d status %0d last %0d, got %0d %0d %0d",
                                 results_seen, want.dom, want.stat, want.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 18);
            if (stall_left > 0) m_tready <= 1'b0;
        end else if (!m_tready && aresetn) begin
            if (stall_left <= 1) m_tready <= 1'b1;
            else stall_left--;
        end
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        stim_row_t rows[$];
        int        waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        m_tready <= 1'b1;
        @(posedge aclk);

        // Zero clue, empty-only line, impossible fill, too long a clue, ignored tlast.
        rows.insert(rows.size(), clue_row(6'd0));
        rows.insert(rows.size(), typed_row(2'b11, 2'b00, rldf_pkg::STAT_INVALID));
        rows.insert(rows.size(), typed_row(rldf_pkg::DOM_EMPTY | rldf_pkg::DOM_FILLED,
                                           rldf_pkg::DOM_EMPTY, rldf_pkg::STAT_OK));
        rows.insert(rows.size(), typed_row(rldf_pkg::DOM_FILLED, 2'b00,
                                           rldf_pkg::STAT_CONTRA));
        rows.insert(rows.size(), clue_row(6'd63));
        rows.insert(rows.size(), typed_row(2'b11, 2'b00, rldf_pkg::STAT_INVALID));
        rows.insert(rows.size(), clue_row(6'd1));
        rows.insert(rows.size(), typed_row(2'b00, 2'b00, rldf_pkg::STAT_CONTRA));
        rows.insert(rows.size(), clue_row(6'd1, 1'b1));
        rows.insert(rows.size(), cell_row(2'b11, 1'b0));
        rows.insert(rows.size(), cell_row(2'b11, 1'b1));
        rows.insert(rows.size(), clue_row(6'd2));
        rows.insert(rows.size(), clue_row(6'd1));
        rows.insert(rows.size(), cell_row(2'b11, 1'b0));
        rows.insert(rows.size(), cell_row(2'b11, 1'b0));
        rows.insert(rows.size(), cell_row(2'b11, 1'b0));
        rows.insert(rows.size(), cell_row(2'b11, 1'b1));
        rows.insert(rows.size(), clue_row(6'd3));
        rows.insert(rows.size(), cell_row(2'b11, 1'b0));
        rows.insert(rows.size(), cell_row(rldf_pkg::DOM_EMPTY, 1'b0));
        rows.insert(rows.size(), cell_row(2'b11, 1'b1));
        foreach (rows[i]) send_item(rows[i]);

        // Wait for the whole backlog to drain before overflowing the stores.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (narrowed_q.size() != 0);
        for (int i = 0; i < CLUES + 1; i++) send_item(clue_row(6'd1));
        send_item(typed_row(2'b11, 2'b00, rldf_pkg::STAT_OVERFLOW));
        for (int i = 0; i < LINES; i++) send_item(cell_row(2'($urandom), 1'b0));
        send_item(typed_row(2'b11, 2'b00, rldf_pkg::STAT_OVERFLOW));

        while (items_sent < 220) begin
            if ($urandom_range(0, 5) == 0) no_gaps = ~no_gaps;
            send_random_line();
        end
        s_tvalid <= 1'b0;
        no_gaps = 1'b0;

        waited = 0;
        while (narrowed_q.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (400) @(posedge aclk);
        $display("Sent %0d items in %0d lines, checked %0d results.",
                 items_sent, lines_done, results_seen);
        $display("Covered invalid and oversized clues, store overflow, contradictions.");
        if (mismatches == 0 && narrowed_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
